[rtl/core/itda_pkg.sv]
// Shared constants for the integer to decimal ASCII converter.
package itda_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_BITS = 4;
	localparam int BITS_PER_STEP = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int CHAR_BITS = 6;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE = 6'd57;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

endpackage

[rtl/core/itda_if.sv]
// Valid/ready channel interfaces for integer input and character output.
interface itda_value_if #(
	parameter int W = 32
);
	logic valid;
	logic ready;
	logic signed [W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface itda_char_if;
	logic valid;
	logic ready;
	logic [5:0] char_code;
	logic last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

[rtl/core/itda_front.sv]
// Front end: accepts integers and splits them into sign and unsigned magnitude.
module itda_front import itda_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	itda_value_if.sink            value_ch,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [VALUE_BITS:0]   push_data
);

	logic                  valid_s1;
	logic                  neg_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	logic                  neg;
	logic [VALUE_BITS-1:0] raw;

	assign value_ch.ready = !valid_s1 || push_ready;
	assign raw = value_ch.value;
	assign neg = raw[VALUE_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (value_ch.ready) begin
			valid_s1 <= value_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (value_ch.ready && value_ch.valid) begin
			neg_s1 <= neg;
			mag_s1 <= neg ? VALUE_BITS'(~raw + 1'b1) : raw;
		end
	end

	assign push_valid = valid_s1;
	assign push_data = {neg_s1, mag_s1};

endmodule

[rtl/core/itda_queue.sv]
// Short FIFO that decouples the front end from the digit back end.
module itda_queue import itda_pkg::*; #(
	parameter int W = VALUE_BITS_DEF + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/itda_back.sv]
// Back end: shift-add-3 binary to BCD conversion and character emission.
module itda_back import itda_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  logic [VALUE_BITS:0] pop_data,
	itda_char_if.source         char_ch
);

	localparam int MAG_W = ((VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
	localparam int STEPS = MAG_W / BITS_PER_STEP;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int IDX_W = $clog2(NDIG);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_FIND = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                       state_q;
	logic                             neg_q;
	logic                             sign_pend_q;
	logic [MAG_W-1:0]                 shift_q;
	logic [NDIG-1:0][DIGIT_BITS-1:0]  bcd_q;
	logic [STEP_W-1:0]                step_q;
	logic [IDX_W-1:0]                 idx_q;
	logic                             out_valid_q;
	logic [CHAR_BITS-1:0]             char_q;
	logic                             last_q;

	logic [NDIG-1:0][DIGIT_BITS-1:0]  conv_bcd;
	logic [MAG_W-1:0]                 conv_shift;
	logic [IDX_W-1:0]                 msd;
	logic                             load_out;

	assign pop_ready = state_q == ST_IDLE;
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || char_ch.ready);

	always_comb begin
		conv_bcd = bcd_q;
		conv_shift = shift_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (conv_bcd[d] >= 4'd5) begin
					conv_bcd[d] = conv_bcd[d] + 4'd3;
				end
			end
			{conv_bcd, conv_shift} = {conv_bcd, conv_shift} << 1;
		end
	end

	always_comb begin
		msd = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) begin
				msd = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out && !sign_pend_q && idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (char_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					neg_q <= pop_data[VALUE_BITS];
					shift_q <= MAG_W'(pop_data[VALUE_BITS-1:0]);
					bcd_q <= '0;
					step_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= conv_bcd;
				shift_q <= conv_shift;
				step_q <= step_q + 1'b1;
			end
			ST_FIND: begin
				idx_q <= msd;
				sign_pend_q <= neg_q;
			end
			ST_EMIT: begin
				if (load_out) begin
					if (sign_pend_q) begin
						char_q <= CHAR_MINUS;
						last_q <= 1'b0;
						sign_pend_q <= 1'b0;
					end else begin
						char_q <= CHAR_ZERO + CHAR_BITS'(bcd_q[idx_q]);
						last_q <= idx_q == '0;
						if (idx_q != '0) begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign char_ch.valid = out_valid_q;
	assign char_ch.char_code = char_q;
	assign char_ch.last = last_q;

endmodule

[rtl/core/int_to_decimal_ascii_unit.sv]
// Top level: signed integer to decimal ASCII character stream.
// The back end converts four magnitude bits per cycle over STEPS conversion steps,
// where STEPS = ceil(VALUE_BITS / 4), then emits one character a cycle while the output
// is not stalled; it takes no new integer from the queue until it has loaded the last
// character of the current one; the front end and the queue buffer integers meanwhile.
// Reset: asynchronous, active low, clears the queue, the state machine and all valid flags.
module int_to_decimal_ascii_unit import itda_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	itda_value_if.sink  value_ch,
	itda_char_if.source char_ch
);

	logic                push_valid;
	logic                push_ready;
	logic [VALUE_BITS:0] push_data;
	logic                pop_valid;
	logic                pop_ready;
	logic [VALUE_BITS:0] pop_data;

	itda_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_ch  (value_ch),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	itda_queue #(
		.W(VALUE_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	itda_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.char_ch  (char_ch)
	);

endmodule

[rtl/core/itda_checker.sv]
// Port-level checker for the converter and its bind to the top level.
module itda_checker import itda_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] char_code,
	input logic       last
);

	logic mid_q;
	logic xfer;

	assign xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (xfer) begin
			mid_q <= !last;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last))
		else $error("Stalled character transaction changed.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == CHAR_MINUS) ||
			(char_code >= CHAR_ZERO && char_code <= CHAR_NINE))
		else $error("Character code outside the minus sign and digits.");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_code == CHAR_MINUS |-> !last)
		else $error("Minus sign marked as the last character.");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> char_code != CHAR_MINUS)
		else $error("Minus sign inside a number's text.");

endmodule

bind int_to_decimal_ascii_unit itda_checker u_itda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(char_ch.valid),
	.out_ready(char_ch.ready),
	.char_code(char_ch.char_code),
	.last     (char_ch.last)
);
